// ===== rtl/chkv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chkv_pkg
// Shared types, sizes and codes of the chained hash key-value store.
// ----------------------------------------------------------------------------
package chkv_pkg;

   localparam int NUM_BUCKETS = 17;
   localparam int CHAIN_SLOTS = 8;
   localparam int TOTAL_SLOTS = NUM_BUCKETS * CHAIN_SLOTS;

   localparam int BUCKET_W = $clog2(NUM_BUCKETS);
   localparam int SLOT_W   = (CHAIN_SLOTS > 1) ? $clog2(CHAIN_SLOTS) : 1;
   localparam int COUNT_W  = $clog2(TOTAL_SLOTS + 1);

   // exact reciprocal for a 32-bit dividend: q = (mag * RECIP) >> DIV_SHIFT
   localparam int          DIV_SHIFT = 32 + $clog2(NUM_BUCKETS);
   localparam logic [32:0] RECIP     = 33'(((64'd1 << DIV_SHIFT) + 64'(NUM_BUCKETS) - 64'd1)
                                           / 64'(NUM_BUCKETS));

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_LOOKUP = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;
   localparam logic [1:0] ACT_CLEAR  = 2'd3;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_MISSING = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;

   typedef struct packed {
      logic [31:0] value;
      logic [31:0] key;
   } slot_type;

   typedef slot_type [CHAIN_SLOTS-1:0] row_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] hit_idx;
      logic              has_free;
      logic [SLOT_W-1:0] free_idx;
   } match_type;

endpackage

// ===== rtl/chkv_row_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chkv_row_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module chkv_row_ram #(
   parameter int DEPTH = 17,
   parameter int WIDTH = 512
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/chkv_bucket_calc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chkv_bucket_calc
// Key magnitude modulo the bucket count, by reciprocal multiply over two stages.
// ----------------------------------------------------------------------------
module chkv_bucket_calc
   import chkv_pkg::*;
(
   input  logic                clock,
   input  logic                load,
   input  logic [31:0]         key_in,
   output logic [BUCKET_W-1:0] bucket
);

   logic [31:0] mag_ff;
   logic [31:0] mag_in;
   logic [31:0] q_ff;
   logic [63:0] prod_lo;
   logic [64:0] prod;
   logic [64:0] q_full;
   logic [31:0] rem;

   // most negative key wraps to 2^31 as unsigned
   assign mag_in = key_in[31] ? (32'd0 - key_in) : key_in;

   // 32x33 product as a 32x32 partial product plus the shifted top bit
   assign prod_lo = {32'd0, mag_ff} * {32'd0, RECIP[31:0]};
   assign prod    = {1'b0, prod_lo} + (RECIP[32] ? {1'b0, mag_ff, 32'd0} : 65'd0);
   assign q_full  = prod >> DIV_SHIFT;

   always_ff @(posedge clock) begin
      if (load) begin
         mag_ff <= mag_in;
      end
      q_ff <= q_full[31:0];
   end

   assign rem    = mag_ff - (q_ff * 32'(NUM_BUCKETS));
   assign bucket = rem[BUCKET_W-1:0];

endmodule

// ===== rtl/chkv_slot_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chkv_slot_match
// Compares a key against every slot of one bucket row, finds the first free slot.
// ----------------------------------------------------------------------------
module chkv_slot_match
   import chkv_pkg::*;
(
   input  row_type                row,
   input  logic [CHAIN_SLOTS-1:0] valid,
   input  logic [31:0]            key,
   output match_type              match
);

   always_comb begin
      match = '0;
      // walk downward so the lowest index wins
      for (int i = CHAIN_SLOTS - 1; i >= 0; i--) begin
         if (valid[i] && (row[i].key == key)) begin
            match.hit     = 1'b1;
            match.hit_idx = SLOT_W'(i);
         end
         if (!valid[i]) begin
            match.has_free = 1'b1;
            match.free_idx = SLOT_W'(i);
         end
      end
   end

endmodule

// ===== rtl/chained_hash_key_value_store_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_key_value_store_unit
// Key-value store, one bucket row per memory word, chained slots per bucket.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                               | tuser
//  req     | in  | key[31:0], item_value[63:32]        | action[1:0]
//  rsp     | out | found_value[31:0], entry_count[39:32] | status[1:0]
//
//  An item passes through accept, reciprocal multiply, remainder and row
//  read, then compare and write back; the bucket divide and the registered
//  row memory read set these steps.
//  Reset clears slot valid bits and the entry count at once; no clearing pass.
//  A result waits in the output register; the compare step holds while it
//  is still unread, and the next beat is taken once that step is done.
// ----------------------------------------------------------------------------
module chained_hash_key_value_store_unit
   import chkv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // key[31:0], item_value[63:32]
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // found_value[31:0], entry_count[39:32]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_MOD  = 2'd2;
   localparam logic [1:0] S_CMP  = 2'd3;

   logic [1:0]                             state_ff, state_in;
   logic [1:0]                             action_ff;
   logic [31:0]                            key_ff;
   logic [31:0]                            value_ff;
   logic [BUCKET_W-1:0]                    bucket_ff;
   logic [NUM_BUCKETS-1:0][CHAIN_SLOTS-1:0] valid_ff, valid_in;
   logic [COUNT_W-1:0]                     count_ff, count_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]                             status_ff, status_in;
   logic [31:0]                            found_ff, found_in;
   logic [7:0]                             entry_ff, entry_in;

   logic                req_beat;
   logic                out_free;
   logic                cmp_go;
   logic [BUCKET_W-1:0] bucket;
   row_type             rd_row;
   row_type             wr_row;
   logic                wr_en;
   match_type           match;
   logic [COUNT_W+7:0]  count_ext;

   assign req_tready = (state_ff == S_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign cmp_go     = (state_ff == S_CMP) && out_free;

   chkv_bucket_calc u_bucket (
      .clock  (clock),
      .load   (req_beat),
      .key_in (req_tdata[31:0]),
      .bucket (bucket)
   );

   chkv_row_ram #(
      .DEPTH (NUM_BUCKETS),
      .WIDTH ($bits(row_type))
   ) u_ram (
      .clock   (clock),
      .rd_en   (state_ff == S_MOD),
      .rd_addr (bucket),
      .rd_data (rd_row),
      .wr_en   (wr_en),
      .wr_addr (bucket_ff),
      .wr_data (wr_row)
   );

   chkv_slot_match u_match (
      .row   (rd_row),
      .valid (valid_ff[bucket_ff]),
      .key   (key_ff),
      .match (match)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_beat) state_in = S_DIV;
         S_DIV:   state_in = S_MOD;
         S_MOD:   state_in = S_CMP;
         S_CMP:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      valid_in  = valid_ff;
      count_in  = count_ff;
      status_in = STAT_OK;
      found_in  = 32'd0;
      wr_row    = rd_row;
      wr_en     = 1'b0;
      case (action_ff)
         ACT_INSERT: begin
            if (match.hit) begin
               wr_row[match.hit_idx].value = value_ff;
               wr_en                       = cmp_go;
            end else if (match.has_free) begin
               wr_row[match.free_idx].key   = key_ff;
               wr_row[match.free_idx].value = value_ff;
               wr_en                        = cmp_go;
               valid_in[bucket_ff][match.free_idx] = 1'b1;
               count_in = count_ff + COUNT_W'(1);
            end else begin
               status_in = STAT_FULL;
            end
         end
         ACT_LOOKUP: begin
            if (match.hit) begin
               found_in = rd_row[match.hit_idx].value;
            end else begin
               status_in = STAT_MISSING;
            end
         end
         ACT_REMOVE: begin
            if (match.hit) begin
               found_in = rd_row[match.hit_idx].value;
               valid_in[bucket_ff][match.hit_idx] = 1'b0;
               count_in = count_ff - COUNT_W'(1);
            end else begin
               status_in = STAT_MISSING;
            end
         end
         ACT_CLEAR: begin
            valid_in = '0;
            count_in = '0;
         end
         default: begin
            status_in = STAT_OK;
         end
      endcase
      count_ext = {8'd0, count_in};
      entry_in  = count_ext[7:0];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmp_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmp_go) begin
            valid_ff <= valid_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         action_ff <= req_tuser;
         key_ff    <= req_tdata[31:0];
         value_ff  <= req_tdata[63:32];
      end
      if (state_ff == S_MOD) begin
         bucket_ff <= bucket;
      end
      if (cmp_go) begin
         status_ff <= status_in;
         found_ff  <= found_in;
         entry_ff  <= entry_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {entry_ff, found_ff};
   assign rsp_tuser  = status_ff;

endmodule

// ===== test/tb_chained_hash_key_value_store_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chained_hash_key_value_store_unit
// Drives insert, lookup, remove and clear beats into the key-value store and
// checks every response against an in-order shadow copy of the hash table.
// Directed beats cover extreme keys, chain overflow, updates and misses.
// Random beats follow, mostly on a small key pool so that buckets collide
// and fill up. Both sides idle at random, and the response side also holds
// off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb_chained_hash_key_value_store_unit;
   import chkv_pkg::*;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] key;
      logic [31:0] item_value;
   } store_op_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] found_value;
      logic [7:0]  entry_count;
   } store_reply_type;

   localparam int RANDOM_OPS = 750;
   localparam int POOL_SIZE  = 48;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // key[31:0], item_value[63:32]
   logic [1:0]  req_tuser = '0;   // action[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // found_value[31:0], entry_count[39:32]
   logic [1:0]  rsp_tuser;        // status[1:0]

   // shadow copy of the table
   logic [31:0] shadow_keys [TOTAL_SLOTS];
   logic [31:0] shadow_values [TOTAL_SLOTS];
   logic        shadow_valid [TOTAL_SLOTS];
   int          shadow_count;

   store_op_type    ops_to_send [$];
   store_reply_type expected_replies [$];
   store_op_type    op_on_bus;
   logic [31:0]     key_pool [POOL_SIZE];

   int total_ops;
   int accepted_ops;
   int mismatch_count;
   int cycle_no;
   int hold_left;
   logic quiet_phase;

   chained_hash_key_value_store_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         cycle_no <= 0;
      end else begin
         cycle_no <= cycle_no + 1;
      end
   end

   // no random idling on either side in this window
   assign quiet_phase = (cycle_no >= 2000) && (cycle_no < 2600);

   // one long response hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (cycle_no == 1200) begin
         hold_left <= 400;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // applies one action to the shadow table and returns the response it gives
   function automatic store_reply_type apply_store_action(store_op_type op);
      store_reply_type reply;
      logic [31:0]     magnitude;
      int              base;
      int              hit;
      int              free_slot;
      magnitude = op.key[31] ? (32'd0 - op.key) : op.key;
      base = int'(magnitude % 32'(NUM_BUCKETS)) * CHAIN_SLOTS;
      hit = -1;
      free_slot = -1;
      reply.status = STAT_OK;
      reply.found_value = '0;
      for (int i = CHAIN_SLOTS - 1; i >= 0; i--) begin
         if (shadow_valid[base + i] && shadow_keys[base + i] == op.key) begin
            hit = base + i;
         end
         if (!shadow_valid[base + i]) begin
            free_slot = base + i;
         end
      end
      case (op.action)
         ACT_CLEAR: begin
            foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
            shadow_count = 0;
         end
         ACT_INSERT: begin
            if (hit >= 0) begin
               shadow_values[hit] = op.item_value;
            end else if (free_slot < 0) begin
               reply.status = STAT_FULL;
            end else begin
               shadow_keys[free_slot] = op.key;
               shadow_values[free_slot] = op.item_value;
               shadow_valid[free_slot] = 1'b1;
               shadow_count++;
            end
         end
         default: begin
            if (hit < 0) begin
               reply.status = STAT_MISSING;
            end else begin
               reply.found_value = shadow_values[hit];
               if (op.action == ACT_REMOVE) begin
                  shadow_valid[hit] = 1'b0;
                  shadow_count--;
               end
            end
         end
      endcase
      reply.entry_count = shadow_count[7:0];
      return reply;
   endfunction

   task automatic queue_op(logic [1:0] action, logic [31:0] key, logic [31:0] item_value);
      store_op_type op;
      op.action = action;
      op.key = key;
      op.item_value = item_value;
      ops_to_send.push_back(op);
      total_ops++;
   endtask

   // driver: predict on each accepted beat, then offer the next one
   always @(posedge clock) begin : driver
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_replies.push_back(apply_store_action(op_on_bus));
            accepted_ops++;
         end
         if (!req_tvalid || req_tready) begin
            if (ops_to_send.size() != 0 && (quiet_phase || $urandom_range(0, 99) >= 19)) begin
               op_on_bus = ops_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {op_on_bus.item_value, op_on_bus.key};
               req_tuser <= op_on_bus.action;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each response beat with the oldest prediction
   always @(posedge clock) begin : monitor
      store_reply_type got;
      store_reply_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (hold_left == 0) && (quiet_phase || $urandom_range(0, 99) >= 19);
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            got.found_value = rsp_tdata[31:0];
            got.entry_count = rsp_tdata[39:32];
            if (expected_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: unexpected beat status=%0d value=%h count=%0d", $time,
                           got.status, got.found_value, got.entry_count);
               end
            end else begin
               want = expected_replies.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: mismatch, expected status %0d value %h count %0d",
                              $time, want.status, want.found_value, want.entry_count);
                     $display("%0t: mismatch, actual   status %0d value %h count %0d",
                              $time, got.status, got.found_value, got.entry_count);
                  end
               end
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      logic [31:0] key;
      int          pick;
      logic [1:0]  action;
      total_ops = 0;
      accepted_ops = 0;
      mismatch_count = 0;
      shadow_count = 0;
      foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;

      // bucket zero: fill the chain, overflow it, update, miss, free a slot
      queue_op(ACT_INSERT, 32'd0, 32'h7fff_ffff);
      for (int i = 1; i < CHAIN_SLOTS; i++) begin
         queue_op(ACT_INSERT, 32'(17 * i), $urandom);
      end
      queue_op(ACT_INSERT, 32'(17 * CHAIN_SLOTS), 32'h1234_5678);
      queue_op(ACT_INSERT, 32'd0, 32'h8000_0000);
      queue_op(ACT_LOOKUP, 32'd0, $urandom);
      queue_op(ACT_LOOKUP, 32'(17 * CHAIN_SLOTS), $urandom);
      queue_op(ACT_REMOVE, 32'd17, $urandom);
      queue_op(ACT_REMOVE, 32'd17, $urandom);
      queue_op(ACT_INSERT, 32'(17 * CHAIN_SLOTS), 32'hffff_ffff);
      // extreme keys, and a negative key sharing a bucket with its magnitude
      queue_op(ACT_INSERT, 32'h8000_0000, 32'h0000_0001);
      queue_op(ACT_INSERT, 32'h7fff_ffff, 32'h8000_0000);
      queue_op(ACT_INSERT, 32'hffff_ffff, 32'hffff_ffff);
      queue_op(ACT_LOOKUP, 32'h8000_0000, $urandom);
      queue_op(ACT_LOOKUP, 32'hffff_ffef, $urandom);
      queue_op(ACT_REMOVE, 32'h7fff_ffff, $urandom);
      queue_op(ACT_CLEAR, $urandom, $urandom);
      queue_op(ACT_LOOKUP, 32'd0, $urandom);

      // small pool spread over four buckets, plus the extreme keys, so chains collide and fill
      for (int i = 0; i < POOL_SIZE; i++) begin
         key = 32'(17 * $urandom_range(0, 5000) + (i % 4) * 4);
         key_pool[i] = $urandom_range(0, 1) ? (32'd0 - key) : key;
      end
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7fff_ffff;

      for (int n = 0; n < RANDOM_OPS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 42) action = ACT_INSERT;
         else if (pick < 70) action = ACT_LOOKUP;
         else if (pick < 99) action = ACT_REMOVE;
         else action = ACT_CLEAR;
         key = ($urandom_range(0, 99) < 75) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                            : 32'($urandom);
         queue_op(action, key, $urandom);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (accepted_ops != total_ops || expected_replies.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
